// ===== design/md5_message_digest_unit_macros.svh =====
// Assertion macros shared by the MD5 digest unit
`ifndef MD5_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define MD5_MESSAGE_DIGEST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset
`define MD5_CHECK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("md5 unit check failed");

// Next-cycle implication, sampled on i_clk, off while in reset
`define MD5_CHECK_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("md5 unit check failed");

`endif

// ===== design/md5_pkg.sv =====
// Package: MD5 constants, round helpers and the block hand-over type
package md5_pkg;

    // Initial chaining value
    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hEFCDAB89;
    localparam logic [31:0] InitC = 32'h98BADCFE;
    localparam logic [31:0] InitD = 32'h10325476;

    localparam int BlockBytes = 64;
    localparam int BlockWords = 16;
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;
    localparam logic [5:0] LastRnd = 6'd63;

    // Sine-derived round constants
    localparam logic [31:0] RoundK [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {phase, round[1:0]}
    localparam logic [4:0] RotS [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // One 64-byte block on its way from the front end to the round engine
    typedef struct packed {
        logic [BlockWords-1:0][31:0] words;
        logic                        last;
    } t_blk;

    // Message word used in a given round
    function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
        logic [3:0] n;
        n = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: msg_idx = n;
            2'd1: msg_idx = 4'(n * 4'd5 + 4'd1);
            2'd2: msg_idx = 4'(n * 4'd3 + 4'd5);
            default: msg_idx = 4'(n * 4'd7);
        endcase
    endfunction

    // Boolean function of the round's phase
    function automatic logic [31:0] round_f(input logic [1:0] phase,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        unique case (phase)
            2'd0: round_f = (b & c) | (~b & d);
            2'd1: round_f = (d & b) | (~d & c);
            2'd2: round_f = b ^ c ^ d;
            default: round_f = c ^ (b | ~d);
        endcase
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        rotl32 = t[63:32];
    endfunction

endpackage

// ===== design/md5_if.sv =====
// Handshake interfaces: message byte input and digest output

interface md5_msg_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] byte_value;
    logic       byte_valid;

    modport source (output valid, op, byte_value, byte_valid, input ready);
    modport sink   (input valid, op, byte_value, byte_valid, output ready);
endinterface

interface md5_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_half;
    logic        digest_last;

    modport source (output valid, digest_half, digest_last, input ready);
    modport sink   (input valid, digest_half, digest_last, output ready);
endinterface

// ===== design/md5_message_digest_unit.sv =====
// Top level: MD5 digest of a byte stream, front end, block queue, round engine
//
//  channel  | dir | payload                             | handshake
//  ---------+-----+-------------------------------------+------------
//  i_msg    | in  | op, byte_value[7:0], byte_valid     | valid/ready
//  o_dig    | out | digest_half[63:0], digest_last      | valid/ready
//
// Bytes go in at one per cycle while the front end takes bytes; a full block waits
// for room in the queue. The round engine loads a block, runs its 64 rounds and
// adds the chaining value before it takes the next block; two blocks may queue.
// The end item adds one or two padded blocks, then two digest items follow.
// Reset is synchronous and needs no clearing pass; either side may stall freely.
`include "md5_message_digest_unit_macros.svh"

module md5_message_digest_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    md5_msg_if.sink     i_msg,
    md5_dig_if.source   o_dig
);

    md5_pkg::t_blk  fe_blk;
    md5_pkg::t_blk  q_blk;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    // Byte packing and padding
    md5_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (i_msg),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_blk   (fe_blk)
    );

    // Block queue
    md5_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_blk   (fe_blk),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_blk   (q_blk),
        .o_empty (q_empty)
    );

    // Compression rounds and digest
    md5_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (q_blk),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_dig   (o_dig)
    );

    // Checks
    `MD5_CHECK_IMP(a_no_push_full, q_push, !q_full)
    `MD5_CHECK_IMP(a_no_pop_empty, q_pop, !q_empty)
    `MD5_CHECK_NXT(a_digest_ends, o_dig.valid && o_dig.ready && o_dig.digest_last, !o_dig.valid)

endmodule

// ===== design/md5_front.sv =====
// Front end: collects bytes into blocks, appends padding and length
module md5_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    md5_msg_if.sink          i_msg,
    input  logic             i_full,
    output logic             o_push,
    output md5_pkg::t_blk    o_blk
);

    typedef enum logic [1:0] {
        F_BYTES,   // taking message bytes
        F_FULL,    // full block waiting for the queue
        F_PAD,     // pad block (with length if it fits)
        F_LEN      // extra block of zeros and length
    } t_fstate;

    t_fstate                    r_state;
    logic [63:0]                r_len;
    logic                       r_end;
    logic [63:0][7:0]           r_buf;

    logic [5:0]                 pos;
    logic                       accept;
    logic                       fits;
    logic [63:0][7:0]           padded;
    logic [63:0][7:0]           lenblk;

    assign pos    = r_len[8:3];
    assign accept = i_msg.valid && i_msg.ready;
    assign fits   = (pos < md5_pkg::LenPos);

    assign i_msg.ready = (r_state == F_BYTES);

    // Pad view of the buffer: marker byte, zeros after it, length on top if it fits
    always_comb begin
        for (int i = 0; i < md5_pkg::BlockBytes; i++) begin
            if (6'(i) == pos) begin
                padded[i] = md5_pkg::PadByte;
            end else if (6'(i) > pos) begin
                padded[i] = '0;
            end else begin
                padded[i] = r_buf[i];
            end
            lenblk[i] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            lenblk[56 + i] = r_len[8*i +: 8];
            if (fits) begin
                padded[56 + i] = r_len[8*i +: 8];
            end
        end
    end

    // Block offered to the queue
    always_comb begin
        o_blk.words = r_buf;
        o_blk.last  = 1'b0;
        unique case (r_state)
            F_BYTES, F_FULL: begin
                o_blk.words = r_buf;
                o_blk.last  = 1'b0;
            end
            F_PAD: begin
                o_blk.words = padded;
                o_blk.last  = fits;
            end
            F_LEN: begin
                o_blk.words = lenblk;
                o_blk.last  = 1'b1;
            end
        endcase
    end

    assign o_push = (r_state != F_BYTES) && !i_full;

    // Byte buffer
    always_ff @(posedge i_clk) begin
        if (accept && i_msg.byte_valid) begin
            r_buf[pos] <= i_msg.byte_value;
        end
    end

    // Control: fill position, length and hand-over sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_BYTES;
            r_len   <= '0;
            r_end   <= 1'b0;
        end else begin
            unique case (r_state)
                F_BYTES: begin
                    if (accept) begin
                        r_end <= i_msg.op;
                        if (i_msg.byte_valid) begin
                            r_len <= r_len + 64'd8;
                            if (pos == md5_pkg::LastRnd) begin
                                r_state <= F_FULL;
                            end else if (i_msg.op) begin
                                r_state <= F_PAD;
                            end
                        end else if (i_msg.op) begin
                            r_state <= F_PAD;
                        end
                    end
                end
                F_FULL: begin
                    if (o_push) begin
                        r_state <= r_end ? F_PAD : F_BYTES;
                    end
                end
                F_PAD: begin
                    if (o_push) begin
                        if (fits) begin
                            r_len   <= '0;
                            r_state <= F_BYTES;
                        end else begin
                            r_state <= F_LEN;
                        end
                    end
                end
                F_LEN: begin
                    if (o_push) begin
                        r_len   <= '0;
                        r_state <= F_BYTES;
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/md5_queue.sv =====
// Short block queue between the front end and the round engine
module md5_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  md5_pkg::t_blk        i_blk,
    output logic                 o_full,
    input  logic                 i_pop,
    output md5_pkg::t_blk        o_blk,
    output logic                 o_empty
);

    md5_pkg::t_blk                     r_mem [md5_pkg::QueueDepth];
    logic [md5_pkg::QueuePtrW-1:0]     r_wptr;
    logic [md5_pkg::QueuePtrW-1:0]     r_rptr;
    logic [md5_pkg::QueueCntW-1:0]     r_cnt;

    assign o_full  = (r_cnt == md5_pkg::QueueCntW'(md5_pkg::QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_blk   = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_blk;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == md5_pkg::QueuePtrW'(md5_pkg::QueueDepth - 1))
                          ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == md5_pkg::QueuePtrW'(md5_pkg::QueueDepth - 1))
                          ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/md5_core.sv =====
// Round engine: one MD5 round per cycle, chaining value and digest output
module md5_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  md5_pkg::t_blk    i_blk,
    input  logic             i_empty,
    output logic             o_pop,
    md5_dig_if.source        o_dig
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_RUN,
        C_SUM,
        C_OUT0,
        C_OUT1
    } t_cstate;

    t_cstate                 r_state;
    logic [3:0][31:0]        r_h;
    logic [31:0]             r_a, r_b, r_c, r_d;
    logic [15:0][31:0]       r_w;
    logic [31:0]             r_kw;
    logic [5:0]              r_rnd;
    logic                    r_last;

    logic [5:0]              rnd_nx;
    logic [31:0]             fval;
    logic [31:0]             xsum;
    logic [31:0]             b_nx;

    function automatic logic [31:0] bswap(input logic [31:0] v);
        bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    assign o_pop  = (r_state == C_IDLE) && !i_empty;
    assign rnd_nx = r_rnd + 6'd1;
    assign fval   = md5_pkg::round_f(r_rnd[5:4], r_b, r_c, r_d);
    assign xsum   = r_a + fval + r_kw;
    assign b_nx   = r_b + md5_pkg::rotl32(xsum, md5_pkg::RotS[{r_rnd[5:4], r_rnd[1:0]}]);

    // Digest halves, first byte on top
    assign o_dig.valid       = (r_state == C_OUT0) || (r_state == C_OUT1);
    assign o_dig.digest_last = (r_state == C_OUT1);
    assign o_dig.digest_half = (r_state == C_OUT1) ? {bswap(r_h[2]), bswap(r_h[3])}
                                                   : {bswap(r_h[0]), bswap(r_h[1])};

    // Round datapath; constant plus message word is registered for the coming round
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_w    <= i_blk.words;
            r_last <= i_blk.last;
            r_kw   <= md5_pkg::RoundK[0] + i_blk.words[0];
            r_a    <= r_h[0];
            r_b    <= r_h[1];
            r_c    <= r_h[2];
            r_d    <= r_h[3];
        end else if (r_state == C_RUN) begin
            r_a  <= r_d;
            r_d  <= r_c;
            r_c  <= r_b;
            r_b  <= b_nx;
            r_kw <= md5_pkg::RoundK[rnd_nx] + r_w[md5_pkg::msg_idx(rnd_nx)];
        end
    end

    // Sequencer and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_rnd   <= '0;
            r_h     <= {md5_pkg::InitD, md5_pkg::InitC, md5_pkg::InitB, md5_pkg::InitA};
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (o_pop) begin
                        r_rnd   <= '0;
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    r_rnd <= rnd_nx;
                    if (r_rnd == md5_pkg::LastRnd) begin
                        r_state <= C_SUM;
                    end
                end
                C_SUM: begin
                    r_h[0]  <= r_h[0] + r_a;
                    r_h[1]  <= r_h[1] + r_b;
                    r_h[2]  <= r_h[2] + r_c;
                    r_h[3]  <= r_h[3] + r_d;
                    r_state <= r_last ? C_OUT0 : C_IDLE;
                end
                C_OUT0: begin
                    if (o_dig.ready) begin
                        r_state <= C_OUT1;
                    end
                end
                C_OUT1: begin
                    if (o_dig.ready) begin
                        r_h     <= {md5_pkg::InitD, md5_pkg::InitC,
                                    md5_pkg::InitB, md5_pkg::InitA};
                        r_state <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule
